// ----- hw/rtl/cbd_pkg.sv -----
// Package with the types, codes and helpers of the chunked body deframer.
`timescale 1ns / 1ps

package cbd_pkg;

	// Width of the chunk size accumulator and of the payload down-counter
	localparam int SIZE_WIDTH = 32;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		PH_LINE = 2'd0,
		PH_DATA = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		K_DATA  = 2'd0,
		K_END   = 2'd1,
		K_BAD   = 2'd2,
		K_TRUNC = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       link_closed;
	} cbd_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
	} cbd_out_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Decode one ASCII hex digit
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b0;
		d.value = 4'h0;
		if (c inside {[8'h30:8'h39]}) begin
			d.ok    = 1'b1;
			d.value = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			d.ok    = 1'b1;
			d.value = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			d.ok    = 1'b1;
			d.value = 4'(c - 8'h37);
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/cbd_in_stage.sv -----
// Input register stage of the chunked body deframer.
`timescale 1ns / 1ps

module cbd_in_stage
	import cbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    raw_valid,
	output logic    raw_stall,
	input  cbd_in_t raw_word,
	input  logic    advance,
	output logic    valid_s1,
	output cbd_in_t word_s1
);

	logic take;

	// Hold a word while the core cannot advance it
	assign raw_stall = valid_s1 && !advance;
	assign take      = raw_valid && !raw_stall;

	// Track occupancy of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= raw_word;
		end
	end

endmodule

// ----- hw/rtl/cbd_core.sv -----
// Deframing state machine and result register of the chunked body deframer.
`timescale 1ns / 1ps

module cbd_core
	import cbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_s1,
	input  cbd_in_t  word_s1,
	output logic     advance,
	output logic     body_valid,
	input  logic     body_stall,
	output cbd_out_t body_word
);

	phase_t                phase_q, phase_d;
	logic [SIZE_WIDTH-1:0] remaining_q, remaining_d;
	logic [SIZE_WIDTH-1:0] accum_q, accum_d;
	logic                  nonempty_q, nonempty_d;
	logic                  cr_q, cr_d;
	logic                  bad_q, bad_d;

	logic                  res_valid;
	cbd_out_t              res;
	logic                  valid_s2;
	cbd_out_t              word_s2;

	logic                  is_cr, is_lf, line_end, overflow;
	hex_digit_t            digit;

	// Decode the current byte
	assign is_cr    = (word_s1.in_byte == CHAR_CR);
	assign is_lf    = (word_s1.in_byte == CHAR_LF);
	assign digit    = hex_decode(word_s1.in_byte);
	assign line_end = cr_q && is_lf;
	assign overflow = (accum_q[SIZE_WIDTH-1 -: 4] != 4'h0);

	// Advance when the result register is free or being drained
	assign advance = valid_s1 && (!valid_s2 || !body_stall);

	// Next state
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		accum_d     = accum_q;
		nonempty_d  = nonempty_q;
		cr_d        = cr_q;
		bad_d       = bad_q;
		case (phase_q)
			PH_DATA: begin
				if (!word_s1.link_closed) begin
					remaining_d = remaining_q - SIZE_WIDTH'(1);
					if (remaining_q == SIZE_WIDTH'(1)) begin
						phase_d    = PH_LINE;
						accum_d    = '0;
						nonempty_d = 1'b0;
						cr_d       = 1'b0;
						bad_d      = 1'b0;
					end
				end
			end
			PH_LINE: begin
				if (word_s1.link_closed) begin
					phase_d = PH_DONE;
				end else if (line_end) begin
					accum_d    = '0;
					nonempty_d = 1'b0;
					cr_d       = 1'b0;
					bad_d      = 1'b0;
					if (bad_q) begin
						phase_d = PH_DONE;
					end else if (nonempty_q) begin
						if (accum_q == '0) begin
							phase_d = PH_DONE;
						end else begin
							remaining_d = accum_q;
							phase_d     = PH_DATA;
						end
					end
				end else begin
					// A CR not followed by LF spoils the line
					if (cr_q) begin
						bad_d      = 1'b1;
						nonempty_d = 1'b1;
					end
					if (is_cr) begin
						cr_d = 1'b1;
					end else begin
						cr_d       = 1'b0;
						nonempty_d = 1'b1;
						if (!digit.ok || overflow) begin
							bad_d = 1'b1;
						end else begin
							accum_d = {accum_q[SIZE_WIDTH-5:0], digit.value};
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result of the current byte
	always_comb begin
		res_valid    = 1'b0;
		res.out_byte = 8'h00;
		res.kind     = K_DATA;
		case (phase_q)
			PH_DATA: begin
				if (!word_s1.link_closed) begin
					res_valid    = 1'b1;
					res.out_byte = word_s1.in_byte;
				end
			end
			PH_LINE: begin
				if (word_s1.link_closed) begin
					res_valid = 1'b1;
					res.kind  = K_TRUNC;
				end else if (line_end) begin
					if (bad_q) begin
						res_valid = 1'b1;
						res.kind  = K_BAD;
					end else if (nonempty_q && accum_q == '0) begin
						res_valid = 1'b1;
						res.kind  = K_END;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Update state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LINE;
			remaining_q <= '0;
			accum_q     <= '0;
			nonempty_q  <= 1'b0;
			cr_q        <= 1'b0;
			bad_q       <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				remaining_q <= remaining_d;
				accum_q     <= accum_d;
				nonempty_q  <= nonempty_d;
				cr_q        <= cr_d;
				bad_q       <= bad_d;
				valid_s2    <= res_valid;
			end else if (!body_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the result payload
	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			word_s2 <= res;
		end
	end

	assign body_valid = valid_s2;
	assign body_word  = word_s2;

endmodule

// ----- hw/rtl/chunked_body_deframer.sv -----
// An accepted byte is held in the input register, then any result in the result register.
// Throughput: one byte per cycle unless body_stall holds; the size line and payload
// state update is one short decode-and-update step between the input and result registers.
// The input stalls only while both the input stage and the result register are full.
// Reset (arst_n low, asynchronous) returns to the size line phase with all counts
// cleared and both stages empty.
`timescale 1ns / 1ps

module chunked_body_deframer
	import cbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     raw_valid,
	output logic     raw_stall,
	input  cbd_in_t  raw_word,
	output logic     body_valid,
	input  logic     body_stall,
	output cbd_out_t body_word
);

	logic    advance;
	logic    valid_s1;
	cbd_in_t word_s1;

	// Register the incoming word
	cbd_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_word  (raw_word),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1)
	);

	// Deframe and register the result
	cbd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1),
		.advance    (advance),
		.body_valid (body_valid),
		.body_stall (body_stall),
		.body_word  (body_word)
	);

endmodule

// ----- hw/rtl/cbd_checker.sv -----
// Port-level assertions for the chunked body deframer and their binding.
`timescale 1ns / 1ps

module cbd_checker
	import cbd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     raw_valid,
	input logic     raw_stall,
	input cbd_in_t  raw_word,
	input logic     body_valid,
	input logic     body_stall,
	input cbd_out_t body_word
);

	// A stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		body_valid && body_stall |=> body_valid && $stable(body_word))
		else $error("stalled result word changed");

	// Status words carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		body_valid |-> (body_word.kind == K_DATA || body_word.out_byte == 8'h00))
		else $error("status word with nonzero byte");

	// Nothing follows a closing status word
	assert property (@(posedge clk) disable iff (!arst_n)
		body_valid && !body_stall && body_word.kind != K_DATA |=> !body_valid)
		else $error("word after closing status");

	// The input stalls only behind a stalled, full output
	assert property (@(posedge clk) disable iff (!arst_n)
		raw_stall |-> body_valid && body_stall)
		else $error("input stalled with output free");

endmodule

bind chunked_body_deframer cbd_checker u_cbd_checker (.*);
